[hw/rtl/best_fit_bar_allocator_core_assert.svh]
// assertion macros shared by the rtl
`ifndef BEST_FIT_BAR_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_BAR_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BFBA_ASSERT_IMPLIES(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed");
`define BFBA_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed");
`else
`define BFBA_ASSERT_IMPLIES(label, clk, rst, cond, conseq)
`define BFBA_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif

`endif

[hw/rtl/bfba_pkg.sv]
package bfba_pkg;

   localparam int LEN_W   = 10;
   localparam int LIMIT_W = 6;
   localparam int IDX_W   = 5;

   localparam logic [LEN_W-1:0]   BAR_LENGTH_RESET = 10'd10;
   localparam logic [LIMIT_W-1:0] BAR_LIMIT_RESET  = 6'd20;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_BAR_LENGTH = 1'b0;
   localparam csr_index_type CSR_BAR_LIMIT  = 1'b1;

   typedef logic [LEN_W-1:0] length_type;

endpackage

[hw/rtl/bfba_ram.sv]
module bfba_ram #(
   parameter int WIDTH  = 10,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/best_fit_bar_allocator_core.sv]
// best fit bar allocator
// request channel (req_valid / req_stall) carries one piece length and an
// end-of-order flag per transfer; the response channel (rsp_valid / rsp_stall)
// returns exactly one result per piece: bar index, placed, opened_new and,
// on the last piece of an order, order_served.
// the csr port writes bar_length (index 0) and bar_limit (index 1); writes
// are meant for when the block is idle.
// a piece's result is registered after a scan of the open bars and a decide
// step: the leftovers are scanned one bar a cycle through the single read
// port of the leftover memory, then the decide state picks the bar and, once
// the output register is free, writes the chosen bar back and registers the
// result. skipped pieces and pieces seen with no bar open go straight to the
// decide state with no scan. the default size is 32 bars.
// one piece is worked on at a time; the next piece is taken as soon as the
// result lies in the output register, even while rsp_stall holds it there.
// if the response is still stalled when the next result is ready, the block
// waits and holds req_stall high.
// reset (synchronous, active high) closes all bars, clears the order failure
// flag and restores bar_length 10 and bar_limit 20; the memory is not cleared.
`include "best_fit_bar_allocator_core_assert.svh"

module best_fit_bar_allocator_core
   import bfba_pkg::*;
#(
   parameter int MAX_BARS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [LEN_W-1:0]   req_piece_length,
   input  logic               req_last_of_order,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_bar_index,
   output logic               rsp_placed,
   output logic               rsp_opened_new,
   output logic               rsp_order_served,
   input  logic               csr_wr_en,
   input  csr_index_type      csr_index,
   input  logic [LEN_W-1:0]   csr_wr_data
);

   localparam int IW = $clog2(MAX_BARS);
   localparam int CW = $clog2(MAX_BARS + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]         state_ff, state_in;
   length_type         piece_ff, piece_in;
   logic               last_ff, last_in;
   logic               skip_ff, skip_in;
   logic [CW-1:0]      rd_cnt_ff, rd_cnt_in;
   logic               pend_ff, pend_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   length_type         best_left_ff, best_left_in;
   logic [CW-1:0]      bars_open_ff, bars_open_in;
   logic               order_failed_ff, order_failed_in;
   length_type         bar_length_ff, bar_length_in;
   logic [LIMIT_W-1:0] bar_limit_ff, bar_limit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_bar_index_ff, rsp_bar_index_in;
   logic               rsp_placed_ff, rsp_placed_in;
   logic               rsp_opened_new_ff, rsp_opened_new_in;
   logic               rsp_order_served_ff, rsp_order_served_in;

   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   length_type         ram_wr_data;
   logic [IW-1:0]      ram_rd_addr;
   length_type         ram_rd_data;

   logic [CW-1:0]      cur_idx;
   length_type         rem;
   logic [LW-1:0]      lim_eff;
   logic               can_open;
   logic               out_free;
   logic               fail;
   logic               failed_now;
   logic               placed;
   logic               opened;
   logic [IW-1:0]      sel_idx;
   logic [IW+IDX_W-1:0] idx_wide;

   bfba_ram #(
      .WIDTH (LEN_W),
      .DEPTH (MAX_BARS)
   ) u_leftover (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cur_idx  = rd_cnt_ff - CW'(1);
   assign rem      = ram_rd_data - piece_ff;
   assign lim_eff  = (LW'(bar_limit_ff) > LW'(MAX_BARS)) ? LW'(MAX_BARS) : LW'(bar_limit_ff);
   assign can_open = (LW'(bars_open_ff) < lim_eff) && (piece_ff <= bar_length_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_wide = {{IDX_W{1'b0}}, sel_idx};

   always_comb begin
      state_in            = state_ff;
      piece_in            = piece_ff;
      last_in             = last_ff;
      skip_in             = skip_ff;
      rd_cnt_in           = rd_cnt_ff;
      pend_in             = 1'b0;
      found_in            = found_ff;
      best_idx_in         = best_idx_ff;
      best_left_in        = best_left_ff;
      bars_open_in        = bars_open_ff;
      order_failed_in     = order_failed_ff;
      bar_length_in       = bar_length_ff;
      bar_limit_in        = bar_limit_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_bar_index_in    = rsp_bar_index_ff;
      rsp_placed_in       = rsp_placed_ff;
      rsp_opened_new_in   = rsp_opened_new_ff;
      rsp_order_served_in = rsp_order_served_ff;
      ram_wr_en           = 1'b0;
      ram_wr_addr         = best_idx_ff;
      ram_wr_data         = best_left_ff;
      ram_rd_addr         = rd_cnt_ff[IW-1:0];
      fail                = 1'b0;
      placed              = 1'b0;
      opened              = 1'b0;
      sel_idx             = '0;
      failed_now          = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BAR_LENGTH: bar_length_in = csr_wr_data;
            CSR_BAR_LIMIT:  bar_limit_in  = csr_wr_data[LIMIT_W-1:0];
            default:        bar_length_in = bar_length_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               piece_in     = req_piece_length;
               last_in      = req_last_of_order;
               skip_in      = order_failed_ff;
               found_in     = 1'b0;
               best_idx_in  = '0;
               best_left_in = '0;
               if (order_failed_ff || (bars_open_ff == '0)) begin
                  state_in = ST_DECIDE;
               end else begin
                  ram_rd_addr = '0;
                  pend_in     = 1'b1;
                  rd_cnt_in   = CW'(1);
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (pend_ff && (ram_rd_data >= piece_ff) && (!found_ff || (rem < best_left_ff))) begin
               found_in     = 1'b1;
               best_idx_in  = cur_idx[IW-1:0];
               best_left_in = rem;
            end
            if (rd_cnt_ff < bars_open_ff) begin
               ram_rd_addr = rd_cnt_ff[IW-1:0];
               pend_in     = 1'b1;
               rd_cnt_in   = rd_cnt_ff + CW'(1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!skip_ff) begin
               if (found_ff) begin
                  ram_wr_en   = out_free;
                  ram_wr_addr = best_idx_ff;
                  ram_wr_data = best_left_ff;
                  sel_idx     = best_idx_ff;
                  placed      = 1'b1;
               end else if (can_open) begin
                  ram_wr_en   = out_free;
                  ram_wr_addr = bars_open_ff[IW-1:0];
                  ram_wr_data = bar_length_ff - piece_ff;
                  sel_idx     = bars_open_ff[IW-1:0];
                  placed      = 1'b1;
                  opened      = 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end
            failed_now = skip_ff || fail;
            if (out_free) begin
               if (opened) begin
                  bars_open_in = bars_open_ff + CW'(1);
               end
               order_failed_in     = last_ff ? 1'b0 : failed_now;
               rsp_valid_in        = 1'b1;
               rsp_bar_index_in    = idx_wide[IDX_W-1:0];
               rsp_placed_in       = placed;
               rsp_opened_new_in   = opened;
               rsp_order_served_in = last_ff && !failed_now;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pend_ff         <= 1'b0;
         bars_open_ff    <= '0;
         order_failed_ff <= 1'b0;
         bar_length_ff   <= BAR_LENGTH_RESET;
         bar_limit_ff    <= BAR_LIMIT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pend_ff         <= pend_in;
         bars_open_ff    <= bars_open_in;
         order_failed_ff <= order_failed_in;
         bar_length_ff   <= bar_length_in;
         bar_limit_ff    <= bar_limit_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      piece_ff            <= piece_in;
      last_ff             <= last_in;
      skip_ff             <= skip_in;
      rd_cnt_ff           <= rd_cnt_in;
      found_ff            <= found_in;
      best_idx_ff         <= best_idx_in;
      best_left_ff        <= best_left_in;
      rsp_bar_index_ff    <= rsp_bar_index_in;
      rsp_placed_ff       <= rsp_placed_in;
      rsp_opened_new_ff   <= rsp_opened_new_in;
      rsp_order_served_ff <= rsp_order_served_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bar_index    = rsp_bar_index_ff;
   assign rsp_placed       = rsp_placed_ff;
   assign rsp_opened_new   = rsp_opened_new_ff;
   assign rsp_order_served = rsp_order_served_ff;

   `BFBA_ASSERT_IMPLIES(a_bars_within_max, clock, reset, 1'b1, bars_open_ff <= CW'(MAX_BARS))
   `BFBA_ASSERT_IMPLIES(a_scan_has_data, clock, reset, state_ff == ST_SCAN, pend_ff)
   `BFBA_ASSERT_IMPLIES(a_unplaced_clean, clock, reset, rsp_valid_ff && !rsp_placed_ff,
                        !rsp_opened_new_ff && (rsp_bar_index_ff == '0))
   `BFBA_ASSERT_NEXT(a_open_counts, clock, reset, (state_ff == ST_DECIDE) && out_free && opened,
                     bars_open_ff == $past(bars_open_ff) + CW'(1))

endmodule

[dv/tb_best_fit_bar_allocator_core.sv]
`timescale 1ns / 1ps

module tb_best_fit_bar_allocator_core;
   import bfba_pkg::*;

   localparam int MAX_BARS    = 32;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASE_LEN [PHASES]   = '{1023, 512, 100, 37, 1, 0, 0};
   localparam int PHASE_LIMIT [PHASES] = '{8, 16, 24, 63, 32, 1, 0};

   typedef struct packed {
      logic [IDX_W-1:0] bar_index;
      logic             placed;
      logic             opened_new;
      logic             order_served;
   } cut_result_type;

   class bar_cut_scoreboard;
      length_type         leftover_len [MAX_BARS];
      int unsigned        open_count     = 0;
      bit                 order_failed   = 1'b0;
      length_type         new_bar_length = BAR_LENGTH_RESET;
      logic [LIMIT_W-1:0] bar_limit      = BAR_LIMIT_RESET;
      cut_result_type     pending_cuts [$];
      int unsigned        errors         = 0;

      function void write_reg(csr_index_type index, length_type data);
         case (index)
            CSR_BAR_LENGTH: new_bar_length = data;
            CSR_BAR_LIMIT: bar_limit = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_piece(length_type piece, logic last);
         cut_result_type cut;
         bit          found;
         int unsigned best;
         int unsigned lim;
         int unsigned k;
         length_type  best_left;
         length_type  rem;
         cut = '0;
         found = 1'b0;
         best = 0;
         best_left = '0;
         lim = (bar_limit > MAX_BARS) ? MAX_BARS : bar_limit;
         if (!order_failed) begin
            for (k = 0; k < open_count; k++) begin
               if (leftover_len[k] >= piece) begin
                  rem = leftover_len[k] - piece;
                  if (!found || rem < best_left) begin
                     found = 1'b1;
                     best = k;
                     best_left = rem;
                  end
               end
            end
            if (found) begin
               leftover_len[best] = best_left;
               cut.bar_index = best[IDX_W-1:0];
               cut.placed = 1'b1;
            end else if (open_count < lim && piece <= new_bar_length) begin
               leftover_len[open_count] = new_bar_length - piece;
               cut.bar_index = open_count[IDX_W-1:0];
               cut.placed = 1'b1;
               cut.opened_new = 1'b1;
               open_count++;
            end else begin
               order_failed = 1'b1;
            end
         end
         if (last) begin
            cut.order_served = !order_failed;
            order_failed = 1'b0;
         end
         pending_cuts = {pending_cuts, cut};
      endfunction

      function void check_result(cut_result_type got);
         cut_result_type want;
         if (pending_cuts.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: index %0d placed %b new %b served %b",
                        got.bar_index, got.placed, got.opened_new, got.order_served);
            return;
         end
         want = pending_cuts.pop_front();
         if (got.bar_index !== want.bar_index || got.placed !== want.placed ||
             got.opened_new !== want.opened_new || got.order_served !== want.order_served) begin
            errors++;
            if (errors <= 10)
               $display("result mismatch: expected index %0d placed %b new %b served %b, %s",
                        want.bar_index, want.placed, want.opened_new, want.order_served,
                        $sformatf("got index %0d placed %b new %b served %b",
                                  got.bar_index, got.placed, got.opened_new,
                                  got.order_served));
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [LEN_W-1:0]   req_piece_length;
   logic               req_last_of_order;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [IDX_W-1:0]   rsp_bar_index;
   logic               rsp_placed;
   logic               rsp_opened_new;
   logic               rsp_order_served;
   logic               csr_wr_en;
   csr_index_type      csr_index;
   logic [LEN_W-1:0]   csr_wr_data;

   bar_cut_scoreboard cut_board = new;
   bit                gaps_on;
   bit                hold_request;
   int                quiet_cycles;

   best_fit_bar_allocator_core #(
      .MAX_BARS(MAX_BARS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_piece_length (req_piece_length),
      .req_last_of_order(req_last_of_order),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bar_index    (rsp_bar_index),
      .rsp_placed       (rsp_placed),
      .rsp_opened_new   (rsp_opened_new),
      .rsp_order_served (rsp_order_served),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // called at a falling edge, returns at a falling edge with the piece still offered
   task automatic send_piece(length_type piece, logic last);
      if (gaps_on && $urandom_range(99) < 15) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_piece_length = piece;
      req_last_of_order = last;
      do @(posedge clock); while (req_stall);
      cut_board.note_piece(piece, last);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type index, length_type data);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wr_data = data;
      cut_board.write_reg(index, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (cut_board.pending_cuts.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // receiver side
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
         end
         if (hold_left != 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = gaps_on && ($urandom_range(99) < 15);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         cut_board.check_result(cut_result_type'({rsp_bar_index, rsp_placed, rsp_opened_new,
                                                   rsp_order_served}));
   end

   // no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned order_left;
      int unsigned roll;
      int          p;
      int          i;
      length_type  bar_len;
      length_type  piece;
      reset = 1'b1;
      req_valid = 1'b0;
      req_piece_length = '0;
      req_last_of_order = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_BAR_LENGTH;
      csr_wr_data = '0;
      gaps_on = 1'b1;
      hold_request = 1'b0;
      order_left = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no bar may be opened
      write_reg(CSR_BAR_LIMIT, 10'd0);
      send_piece(10'd5, 1'b0);
      send_piece(10'd0, 1'b0);
      send_piece(10'd3, 1'b1);
      send_piece(10'd0, 1'b1);
      drain_results();

      // reset length, exact fits, piece longer than a bar, ties
      write_reg(CSR_BAR_LIMIT, 10'd20);
      send_piece(10'd0, 1'b1);
      send_piece(10'd10, 1'b1);
      send_piece(10'd11, 1'b1);
      send_piece(10'd4, 1'b0);
      send_piece(10'd4, 1'b0);
      send_piece(10'd2, 1'b1);
      send_piece(10'd7, 1'b0);
      send_piece(10'd7, 1'b0);
      send_piece(10'd3, 1'b1);
      send_piece(10'd1023, 1'b1);
      drain_results();

      // longest bar, limit above the bar count
      write_reg(CSR_BAR_LENGTH, 10'd1023);
      write_reg(CSR_BAR_LIMIT, 10'd63);
      send_piece(10'd1023, 1'b1);
      send_piece(10'd512, 1'b0);
      send_piece(10'd0, 1'b1);
      drain_results();

      // limit below the bars already open
      write_reg(CSR_BAR_LIMIT, 10'd2);
      send_piece(10'd600, 1'b1);
      send_piece(10'd511, 1'b1);
      send_piece(10'd0, 1'b0);
      send_piece(10'd1, 1'b1);
      drain_results();

      for (p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            write_reg(CSR_BAR_LENGTH, length_type'($urandom_range(1023)));
            write_reg(CSR_BAR_LIMIT, length_type'($urandom_range(63)));
         end else begin
            write_reg(CSR_BAR_LENGTH, length_type'(PHASE_LEN[p]));
            write_reg(CSR_BAR_LIMIT, length_type'(PHASE_LIMIT[p]));
         end
         bar_len = cut_board.new_bar_length;
         gaps_on = (p != 1);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (order_left == 0)
               order_left = $urandom_range(1, 6);
            order_left--;
            roll = $urandom_range(99);
            if (roll < 10)
               piece = '0;
            else if (roll < 25)
               piece = length_type'($urandom_range(1023));
            else if (roll < 60)
               piece = length_type'($urandom_range(bar_len / 4));
            else
               piece = length_type'($urandom_range(bar_len));
            send_piece(piece, order_left == 0);
            if (p == 0 && i == 100)
               hold_request = 1'b1;
         end
         drain_results();
      end

      if (cut_board.errors == 0 && cut_board.pending_cuts.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bfba_pkg.sv
hw/rtl/bfba_ram.sv
hw/rtl/best_fit_bar_allocator_core.sv
dv/tb_best_fit_bar_allocator_core.sv
